@@ rtl/bitmap_cell_allocator_top_macros.svh @@
// Assertion macros shared by the bitmap cell allocator RTL.
`ifndef BITMAP_CELL_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_CELL_ALLOCATOR_TOP_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define BCA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define BCA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bca_pkg.sv @@
// Package: shared constants, codes and types of the bitmap cell allocator.
`default_nettype none
package bca_pkg;

  localparam int MAP_BYTES_DEF  = 32;
  localparam int CELL_BYTES_DEF = 4;

  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 9;
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 1;

  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'd0;
  localparam logic [ADDR_W-1:0] POOL_LEN_RESET  = 32'd1024;
  localparam logic [7:0]        BYTE_FULL       = 8'hFF;

  // Mode codes; the high bit alone selects clear.
  localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
  localparam int                MODE_CLEAR_BIT = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BASE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_LEN  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC   = 3'd0,
    ST_FULL    = 3'd1,
    ST_FREED   = 3'd2,
    ST_OOB     = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ rtl/bca_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/bca_div.sv @@
// Divider by the constant cell size: one reciprocal multiply, product registered, then quotient registered.
`default_nettype none
module bca_div #(
  parameter int CELL_BYTES = bca_pkg::CELL_BYTES_DEF,
  parameter int QW         = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       dividend,
  output bca_pkg::div_stat_t     stat,
  output logic      [QW-1:0]     quotient
);

  // Dividends stay below CELL_BYTES << QW, so NW bits carry them. A reciprocal
  // rounded up with KW extra fraction bits gives the exact floor over that range.
  localparam int            KW         = $clog2(CELL_BYTES);
  localparam int            NW         = QW + KW;
  localparam int            SH         = NW + KW;
  localparam int            MW         = NW + 2;
  localparam logic [63:0]   RECIP_WIDE = ((64'd1 << SH) + 64'(CELL_BYTES) - 64'd1)
                                         / 64'(CELL_BYTES);
  localparam logic [MW-1:0] RECIP      = MW'(RECIP_WIDE);

  logic [NW+MW-1:0] prod;
  logic             busy;
  logic             done;

  assign stat = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
      if (start) begin
        prod <= {{MW{1'b0}}, dividend[NW-1:0]} * {{NW{1'b0}}, RECIP};
      end
      // Keep the integer part of the scaled product.
      if (busy) begin
        quotient <= prod[SH+QW-1:SH];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bitmap_cell_allocator_top.sv @@
// Top level of the bitmap cell allocator: sequencer, map RAM, divider and result register.
`default_nettype none
`include "bitmap_cell_allocator_top_macros.svh"
// The allocator tracks a pool of MAP_BYTES*8 cells of CELL_BYTES bytes each,
// starting at the configured pool base, with one used bit per cell kept in a
// byte-wide map RAM. Each request is one transfer on the input channel and
// produces exactly one transfer on the output channel. The block takes one
// request at a time: in_ready is high only while the sequencer is idle, but a
// finished result waits in the output register, so the next request can be
// taken before the previous result has been transferred. Allocate scans the
// map one byte per cycle through the RAM read port and ends early when a free
// cell sits in a low byte. Free runs through offset, bounds check, a
// reciprocal multiply that turns the byte offset into a cell index, map read,
// map update and result load; an out-of-bounds address goes from the check
// straight to the result load. Clear rewrites every map byte, one per cycle.
// After reset the same clearing pass runs before the first request is taken;
// configuration writes are taken at any time and must only be issued while no
// request is in flight.
module bitmap_cell_allocator_top #(
  parameter int MAP_BYTES  = bca_pkg::MAP_BYTES_DEF,
  parameter int CELL_BYTES = bca_pkg::CELL_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bca_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bca_pkg::ADDR_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bca_pkg::MODE_W-1:0]        mode,
  input  wire logic [bca_pkg::ADDR_W-1:0]        free_address,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [bca_pkg::STATUS_W-1:0]      status,
  output logic      [bca_pkg::ADDR_W-1:0]        cell_address,
  output logic                                   zero_write_valid,
  output logic      [bca_pkg::ADDR_W-1:0]        zero_write_address,
  output logic      [bca_pkg::COUNT_W-1:0]       allocated_count
);

  localparam int NUM_CELLS = MAP_BYTES * 8;
  localparam int QW        = $clog2(NUM_CELLS);
  localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int SW        = $clog2(MAP_BYTES + 1);
  localparam int CW        = $clog2(NUM_CELLS + 1);

  localparam logic [31:0]   MAP_SPAN  = 32'(NUM_CELLS * CELL_BYTES);
  localparam logic [31:0]   CELL_STEP = 32'(CELL_BYTES);
  localparam logic [SW-1:0] SCAN_END  = SW'(MAP_BYTES);
  localparam logic [SW-1:0] LAST_CNT  = SW'(MAP_BYTES - 1);
  localparam logic [AW-1:0] LAST_BYTE = AW'(MAP_BYTES - 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(NUM_CELLS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_FREE_OFF,
    S_FREE_CHK,
    S_FREE_DIV,
    S_FREE_RD,
    S_FREE_UPD,
    S_RESP
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] pool_base;
  logic [31:0] pool_len;

  // Sequencer registers.
  logic [SW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic          clr_report;
  logic [CW-1:0] count;
  logic [QW-1:0] hit_idx;
  logic [31:0]   prod;
  logic [31:0]   req_addr;
  logic [31:0]   offset;

  // Result held until the output register is free.
  bca_pkg::status_t res_status;
  logic [31:0]      res_cell;
  logic             res_zw_valid;
  logic [31:0]      res_zw_addr;

  // Map RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Divider.
  logic               div_start;
  bca_pkg::div_stat_t div_stat;
  logic [QW-1:0]      quot;

  logic [AW-1:0]   free_byte;
  logic [2:0]      free_bit;
  logic [QW-1:0]   quot_byte;
  logic [2:0]      low_bit;
  logic [CW+8:0]   count_ext;
  logic [31:0]     idx_ext;
  logic            out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign quot_byte = quot >> 3;
  assign free_byte = AW'(quot_byte);
  assign free_bit  = quot[2:0];
  assign count_ext = {9'b0, count};
  assign idx_ext   = {{(32 - QW){1'b0}}, hit_idx};
  assign div_start = (state == S_FREE_CHK) && (offset < pool_len) && (offset < MAP_SPAN);
  // The output register takes a new result when it is empty or being emptied.
  assign out_load  = (state == S_RESP) && (!out_valid || out_ready);

  // Lowest clear bit of the byte under scan.
  always_comb begin
    low_bit = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!ram_rdata[b]) begin
        low_bit = 3'(b);
      end
    end
  end

  // Map RAM addressing: the scan and clear counter drives both ports by default;
  // a scan hit writes at the pending byte and the free steps take the ports over.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = 8'h00;
    ram_raddr = cnt[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        if (pend && (ram_rdata != bca_pkg::BYTE_FULL)) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr;
          ram_wdata = ram_rdata | (8'b1 << low_bit);
        end
      end
      S_FREE_RD: begin
        ram_raddr = free_byte;
      end
      S_FREE_UPD: begin
        if (ram_rdata[free_bit]) begin
          ram_we    = 1'b1;
          ram_waddr = free_byte;
          ram_wdata = ram_rdata & ~(8'b1 << free_bit);
        end
      end
      default: begin
      end
    endcase
  end

  bca_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bca_div #(
    .CELL_BYTES (CELL_BYTES),
    .QW         (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .stat     (div_stat),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      pend       <= 1'b0;
      clr_report <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
      pool_base  <= bca_pkg::POOL_BASE_RESET;
      pool_len   <= bca_pkg::POOL_LEN_RESET;
    end else begin
      // Configuration writes; only the two listed indexes exist.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bca_pkg::CFG_POOL_BASE: pool_base <= cfg_data;
          bca_pkg::CFG_POOL_LEN:  pool_len  <= cfg_data;
          default: begin
          end
        endcase
      end

      // Drop the result once it has been transferred, unless a new one loads.
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + SW'(1);
          if (cnt == LAST_CNT) begin
            if (clr_report) begin
              res_status   <= bca_pkg::ST_CLEARED;
              res_cell     <= '0;
              res_zw_valid <= 1'b0;
              res_zw_addr  <= '0;
              state        <= S_RESP;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            cnt      <= '0;
            pend     <= 1'b0;
            req_addr <= free_address;
            if (mode[bca_pkg::MODE_CLEAR_BIT]) begin
              clr_report <= 1'b1;
              count      <= '0;
              state      <= S_CLEAR;
            end else if (mode == bca_pkg::MODE_ALLOC) begin
              state <= S_SCAN;
            end else begin
              state <= S_FREE_OFF;
            end
          end
        end

        // Issue one read a cycle; check the byte read in the cycle before.
        S_SCAN: begin
          if (cnt != SCAN_END) begin
            cnt       <= cnt + SW'(1);
            pend      <= 1'b1;
            pend_addr <= cnt[AW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (ram_rdata != bca_pkg::BYTE_FULL) begin
              hit_idx <= QW'({pend_addr, low_bit});
              count   <= count + CW'(1);
              state   <= S_ALLOC_MUL;
            end else if (pend_addr == LAST_BYTE) begin
              res_status   <= bca_pkg::ST_FULL;
              res_cell     <= '0;
              res_zw_valid <= 1'b0;
              res_zw_addr  <= '0;
              state        <= S_RESP;
            end
          end
        end

        S_ALLOC_MUL: begin
          prod  <= idx_ext * CELL_STEP;
          state <= S_ALLOC_ADD;
        end

        S_ALLOC_ADD: begin
          res_status   <= bca_pkg::ST_ALLOC;
          res_cell     <= pool_base + prod;
          res_zw_valid <= 1'b1;
          res_zw_addr  <= pool_base + prod;
          state        <= S_RESP;
        end

        S_FREE_OFF: begin
          offset <= req_addr - pool_base;
          state  <= S_FREE_CHK;
        end

        // Out of bounds either past the configured length or past the map.
        S_FREE_CHK: begin
          if (div_start) begin
            state <= S_FREE_DIV;
          end else begin
            res_status   <= bca_pkg::ST_OOB;
            res_cell     <= '0;
            res_zw_valid <= 1'b0;
            res_zw_addr  <= '0;
            state        <= S_RESP;
          end
        end

        S_FREE_DIV: begin
          if (div_stat.done) begin
            state <= S_FREE_RD;
          end
        end

        S_FREE_RD: begin
          state <= S_FREE_UPD;
        end

        S_FREE_UPD: begin
          res_cell <= '0;
          if (ram_rdata[free_bit]) begin
            if (count != '0) begin
              count <= count - CW'(1);
            end
            res_status   <= bca_pkg::ST_FREED;
            res_zw_valid <= 1'b1;
            res_zw_addr  <= req_addr;
          end else begin
            res_status   <= bca_pkg::ST_DOUBLE;
            res_zw_valid <= 1'b0;
            res_zw_addr  <= '0;
          end
          state <= S_RESP;
        end

        // Hold until the output register is free, then load it.
        S_RESP: begin
          if (out_load) begin
            out_valid          <= 1'b1;
            status             <= res_status;
            cell_address       <= res_cell;
            zero_write_valid   <= res_zw_valid;
            zero_write_address <= res_zw_addr;
            allocated_count    <= count_ext[8:0];
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BCA_CHECK(a_count_bound, count <= COUNT_MAX, "allocated count exceeds pool size")
  `BCA_CHECK(a_div_done_in_wait, div_stat.done |-> state == S_FREE_DIV, "divider done outside wait")
  `BCA_CHECK(a_div_busy_not_ready, div_stat.busy |-> !in_ready, "request taken while dividing")
  `BCA_CHECK(a_alloc_zero_write, (out_valid && status == bca_pkg::ST_ALLOC) |-> (zero_write_valid && zero_write_address == cell_address), "alloc without matching zero write")
  `BCA_CHECK_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "sequencer idle after transfer")

endmodule
`default_nettype wire
